/* hw/rtl/bstack_pkg.sv */
`default_nettype none
package bstack_pkg;

  localparam int unsigned STACK_BYTES_DEF = 4096;
  localparam int unsigned PTR_W = 13;
  localparam logic [PTR_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_DUP  = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH,
    S_POP,
    S_DUP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [1:0]       width_code;
    logic [63:0]      push_value;
    logic [PTR_W-1:0] dup_bytes;
  } in_item_t;

  typedef struct packed {
    logic [63:0]      pop_value;
    logic [1:0]       status;
    logic [PTR_W-1:0] depth;
  } out_item_t;

endpackage
`default_nettype wire

/* hw/rtl/byte_stack_push_pop_dup.sv */
`default_nettype none
// Byte-addressed operand stack: push stores the low 1, 2, 4 or 8 bytes of a value
// little-endian at the pointer, pop returns them zero-extended, duplicate copies the
// top dup_bytes bytes onto the top. Overflow is checked against min(cfg_wdata limit,
// STACK_BYTES), underflow against the pointer; on error the pointer is unchanged and
// pop_value is 0. All byte traffic goes through one byte-wide RAM with one write and
// one registered read port, one byte per cycle. After acceptance an execute state checks
// the bounds and moves the pointer; a push, pop or duplicate state then moves the bytes
// (1 to 8 for push and pop, dup_bytes for duplicate), and a finish state posts the result;
// errors, no-ops and zero-length duplicates go straight to the finish state. The block
// turns ready in the cycle its result appears. The block takes one transaction at a
// time; a finished result sits in the output register and the next transaction is
// accepted while it waits. The store needs no clearing after reset, since only bytes
// below the pointer are ever read.
module byte_stack_push_pop_dup #(
  parameter int unsigned STACK_BYTES = bstack_pkg::STACK_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire bstack_pkg::in_item_t            in_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output bstack_pkg::out_item_t                out_item,
  input  wire logic                            cfg_we,
  input  wire logic [bstack_pkg::PTR_W-1:0]    cfg_wdata
);
  import bstack_pkg::*;

  localparam int unsigned AW = $clog2(STACK_BYTES);
  localparam logic [31:0] STACK_BYTES_W = 32'(STACK_BYTES);

  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [PTR_W-1:0] limit_r;
  logic [PTR_W-1:0] sp_r, sp_nxt;
  logic [PTR_W-1:0] len_r, len_nxt;
  logic [PTR_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [PTR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic [63:0]      val_r, val_nxt;
  logic [63:0]      popped_r, popped_nxt;
  logic [1:0]       status_r, status_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [PTR_W-1:0] lim;
  logic [PTR_W-1:0] opnd;
  logic [PTR_W:0]   sum;
  logic             over, under;
  logic [PTR_W-1:0] cnt_m1;
  logic             out_free;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic [31:0]      waddr_ext, raddr_ext;

  bstack_ram #(
    .WIDTH (8),
    .DEPTH (STACK_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign waddr_ext = 32'(wr_addr_r);
  assign raddr_ext = 32'(rd_addr_r);
  assign ram_waddr = waddr_ext[AW-1:0];
  assign ram_raddr = raddr_ext[AW-1:0];

  // Effective bound and the shared check adder
  assign lim   = (32'(limit_r) < STACK_BYTES_W) ? limit_r : STACK_BYTES_W[PTR_W-1:0];
  assign opnd  = (item_r.func == FUNC_DUP) ? item_r.dup_bytes
                                           : (13'd1 << item_r.width_code);
  assign sum   = {1'b0, sp_r} + {1'b0, opnd};
  assign over  = sum > {1'b0, lim};
  assign under = sp_r < opnd;

  assign cnt_m1   = cnt_r - 13'd1;
  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (item_r.func)
          FUNC_PUSH: state_nxt = over ? S_FINISH : S_PUSH;
          FUNC_POP:  state_nxt = under ? S_FINISH : S_POP;
          FUNC_DUP: begin
            if (over || under || opnd == '0) state_nxt = S_FINISH;
            else                             state_nxt = S_DUP;
          end
          default:   state_nxt = S_FINISH;
        endcase
      end
      S_PUSH: begin
        if (cnt_r == len_r - 13'd1) state_nxt = S_FINISH;
      end
      S_POP, S_DUP: begin
        if (cnt_r == len_r) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    item_nxt      = item_r;
    sp_nxt        = sp_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    rd_addr_nxt   = rd_addr_r;
    wr_addr_nxt   = wr_addr_r;
    val_nxt       = val_r;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_wdata     = val_r[7:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) item_nxt = in_item;
      end
      S_EXEC: begin
        cnt_nxt     = '0;
        len_nxt     = opnd;
        val_nxt     = item_r.push_value;
        popped_nxt  = '0;
        status_nxt  = STAT_OK;
        wr_addr_nxt = sp_r;
        rd_addr_nxt = sp_r - opnd;
        case (item_r.func)
          FUNC_PUSH: begin
            if (over) status_nxt = STAT_OVERFLOW;
            else      sp_nxt     = sum[PTR_W-1:0];
          end
          FUNC_POP: begin
            if (under) status_nxt = STAT_UNDERFLOW;
            else       sp_nxt     = sp_r - opnd;
          end
          FUNC_DUP: begin
            if (over)       status_nxt = STAT_OVERFLOW;
            else if (under) status_nxt = STAT_UNDERFLOW;
            else            sp_nxt     = sum[PTR_W-1:0];
          end
          default: ;
        endcase
      end
      S_PUSH: begin
        ram_we      = 1'b1;
        val_nxt     = val_r >> 8;
        wr_addr_nxt = wr_addr_r + 13'd1;
        cnt_nxt     = cnt_r + 13'd1;
      end
      S_POP: begin
        // read data for byte cnt-1 lands this cycle
        if (cnt_r != '0) popped_nxt[8*cnt_m1[2:0] +: 8] = ram_rdata;
        if (cnt_r != len_r) begin
          rd_addr_nxt = rd_addr_r + 13'd1;
          cnt_nxt     = cnt_r + 13'd1;
        end
      end
      S_DUP: begin
        ram_wdata = ram_rdata;
        if (cnt_r != '0) begin
          ram_we      = 1'b1;
          wr_addr_nxt = wr_addr_r + 13'd1;
        end
        if (cnt_r != len_r) begin
          rd_addr_nxt = rd_addr_r + 13'd1;
          cnt_nxt     = cnt_r + 13'd1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_nxt.pop_value = popped_r;
          out_nxt.status    = status_r;
          out_nxt.depth     = sp_r;
          out_valid_nxt     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    len_r     <= len_nxt;
    cnt_r     <= cnt_nxt;
    rd_addr_r <= rd_addr_nxt;
    wr_addr_r <= wr_addr_nxt;
    val_r     <= val_nxt;
    popped_r  <= popped_nxt;
    status_r  <= status_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

/* hw/rtl/bstack_ram.sv */
`default_nettype none
module bstack_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/bstack_chk.sv */
`default_nettype none
module bstack_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire bstack_pkg::in_item_t         in_item,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire bstack_pkg::out_item_t        out_item,
  input wire logic                         cfg_we,
  input wire logic [bstack_pkg::PTR_W-1:0] cfg_wdata
);
  import bstack_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // one transaction at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while busy");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status == STAT_OK || out_item.status == STAT_OVERFLOW ||
                  out_item.status == STAT_UNDERFLOW)
    else $error("undefined status code");

  // errors return no data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != STAT_OK |-> out_item.pop_value == '0)
    else $error("nonzero pop value on error");

endmodule

bind byte_stack_push_pop_dup bstack_chk u_bstack_chk (.*);
`default_nettype wire

/* tb/stack_op_checker.sv */
`timescale 1ns / 100ps
module stack_op_checker #(
  parameter int unsigned STACK_BYTES = bstack_pkg::STACK_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  bstack_pkg::in_item_t         in_item,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  bstack_pkg::out_item_t        out_item,
  input  logic                         cfg_we,
  input  logic [bstack_pkg::PTR_W-1:0] cfg_wdata,
  output int                           mismatches,
  output int                           results_outstanding,
  output int                           results_seen,
  output int                           overflow_hits,
  output int                           underflow_hits,
  output int                           peak_depth
);
  import bstack_pkg::*;

  logic [7:0]  stack_bytes [STACK_BYTES];
  int unsigned shadow_sp;
  int unsigned stack_limit;
  out_item_t   expected_q [$];

  // Apply one operation to the shadow stack and return the result it must produce.
  function automatic out_item_t apply_stack_op(in_item_t op);
    out_item_t   res;
    int unsigned bound;
    int unsigned nbytes;
    int unsigned i;
    bound = (stack_limit < STACK_BYTES) ? stack_limit : STACK_BYTES;
    res = '0;
    res.status = STAT_OK;
    case (func_t'(op.func))
      FUNC_PUSH: begin
        nbytes = 1 << op.width_code;
        if (shadow_sp + nbytes > bound) begin
          res.status = STAT_OVERFLOW;
        end else begin
          for (i = 0; i < nbytes; i++) stack_bytes[shadow_sp + i] = op.push_value[8*i +: 8];
          shadow_sp += nbytes;
        end
      end
      FUNC_POP: begin
        nbytes = 1 << op.width_code;
        if (shadow_sp < nbytes) begin
          res.status = STAT_UNDERFLOW;
        end else begin
          shadow_sp -= nbytes;
          for (i = 0; i < nbytes; i++) res.pop_value[8*i +: 8] = stack_bytes[shadow_sp + i];
        end
      end
      FUNC_DUP: begin
        nbytes = 32'(op.dup_bytes);
        // overflow wins over underflow
        if (shadow_sp + nbytes > bound) begin
          res.status = STAT_OVERFLOW;
        end else if (shadow_sp < nbytes) begin
          res.status = STAT_UNDERFLOW;
        end else begin
          for (i = 0; i < nbytes; i++) begin
            stack_bytes[shadow_sp + i] = stack_bytes[shadow_sp - nbytes + i];
          end
          shadow_sp += nbytes;
        end
      end
      default: ;
    endcase
    res.depth = shadow_sp[PTR_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : track
    out_item_t want;
    if (!rst_n) begin
      shadow_sp = 0;
      stack_limit = 32'(LIMIT_RESET);
      expected_q.delete();
    end else begin
      // retire the oldest expectation before queuing one for this edge's input
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result pop=%h status=%0d depth=%0d",
                     $time, out_item.pop_value, out_item.status, out_item.depth);
          end
        end else begin
          want = expected_q.pop_front();
          if (out_item.pop_value !== want.pop_value || out_item.status !== want.status ||
              out_item.depth !== want.depth) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch, expected pop=%h status=%0d depth=%0d",
                       $time, want.pop_value, want.status, want.depth);
              $display("%0t:                  got      pop=%h status=%0d depth=%0d",
                       $time, out_item.pop_value, out_item.status, out_item.depth);
            end
          end
        end
      end
      if (cfg_we) stack_limit = 32'(cfg_wdata);
      if (in_valid && in_ready) begin
        want = apply_stack_op(in_item);
        if (want.status == STAT_OVERFLOW) overflow_hits++;
        if (want.status == STAT_UNDERFLOW) underflow_hits++;
        if (int'(shadow_sp) > peak_depth) peak_depth = int'(shadow_sp);
        expected_q.push_back(want);
      end
    end
    results_outstanding = expected_q.size();
  end

endmodule

/* tb/byte_stack_push_pop_dup_test.sv */
`timescale 1ns / 100ps
module byte_stack_push_pop_dup_test;
  import bstack_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_OFF    = 300;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_item;
  logic             cfg_we;
  logic [PTR_W-1:0] cfg_wdata;

  int mismatches;
  int results_outstanding;
  int results_seen;
  int overflow_hits;
  int underflow_hits;
  int peak_depth;
  int cycle_count;
  int ops_issued;
  int hold_off_reqs;
  int last_depth;
  bit tx_quiet;
  bit rx_quiet;

  byte_stack_push_pop_dup dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  stack_op_checker u_stack_op_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_item            (in_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_item           (out_item),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .mismatches         (mismatches),
    .results_outstanding(results_outstanding),
    .results_seen       (results_seen),
    .overflow_hits      (overflow_hits),
    .underflow_hits     (underflow_hits),
    .peak_depth         (peak_depth)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("byte_stack_push_pop_dup_test: done, errors");
      $finish;
    end
  end

  // Offer one transaction after a random gap and hold it until it is taken.
  task automatic send_op(input func_t op, input logic [1:0] wcode, input logic [63:0] value,
                         input logic [PTR_W-1:0] count);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= '{func: op, width_code: wcode, push_value: value, dup_bytes: count};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    ops_issued++;
  endtask

  // Drop valid and wait until every outstanding result has been taken.
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_stack_limit(input logic [PTR_W-1:0] limit);
    settle_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= limit;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_mix(input int n_items, input int push_w, input int pop_w, input int dup_w,
                         input bit fast);
    int pick;
    int band;
    func_t op;
    logic [PTR_W-1:0] count;
    tx_quiet = fast;
    repeat (n_items) begin
      // one slot past the weights leaves a rare no-op
      pick = $urandom_range(0, push_w + pop_w + dup_w);
      if (pick < push_w) op = FUNC_PUSH;
      else if (pick < push_w + pop_w) op = FUNC_POP;
      else if (pick < push_w + pop_w + dup_w) op = FUNC_DUP;
      else op = FUNC_NOP;
      band = $urandom_range(0, 9);
      if (band < 7) count = PTR_W'($urandom_range(0, 16));
      else if (band < 9) count = PTR_W'($urandom_range(0, 256));
      else count = PTR_W'($urandom_range(0, 8191));
      send_op(op, 2'($urandom_range(0, 3)), {$urandom, $urandom}, count);
    end
    tx_quiet = 1'b0;
  endtask

  // Result side: random stall per transaction, or one long hold-off on request.
  initial begin
    int stall;
    int hold_off_taken;
    out_ready = 1'b0;
    hold_off_taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_reqs != hold_off_taken) begin
        stall = HOLD_OFF;
        hold_off_taken = hold_off_reqs;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, 17);
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      last_depth = int'(out_item.depth);
    end
  end

  initial begin
    int k;
    int unsigned fill;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    ops_issued = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // empty stack: underflow on pop and duplicate, zero-length duplicate, no-op
    send_op(FUNC_POP, 2'd0, '0, '0);
    send_op(FUNC_DUP, 2'd0, '0, 13'd1);
    send_op(FUNC_DUP, 2'd3, '1, 13'd0);
    send_op(FUNC_NOP, 2'd3, '1, '1);
    // every width with extreme values, depth reaches 23 and a duplicate of all 23 bytes makes it 46
    send_op(FUNC_PUSH, 2'd0, '1, '0);
    send_op(FUNC_PUSH, 2'd1, '0, '1);
    send_op(FUNC_PUSH, 2'd2, '1, '0);
    send_op(FUNC_PUSH, 2'd3, 64'h0123_4567_89ab_cdef, '0);
    send_op(FUNC_PUSH, 2'd3, '1, '0);
    send_op(FUNC_DUP, 2'd0, '0, 13'd23);
    // oversized duplicates overflow
    send_op(FUNC_DUP, 2'd0, '0, 13'd8191);
    send_op(FUNC_DUP, 2'd0, '0, 13'd4096);
    send_op(FUNC_POP, 2'd3, '0, '0);
    send_op(FUNC_POP, 2'd2, '0, '0);
    send_op(FUNC_POP, 2'd1, '0, '0);
    send_op(FUNC_POP, 2'd0, '0, '0);
    // depth 31 against a limit of 32
    set_stack_limit(13'd32);
    send_op(FUNC_PUSH, 2'd1, '1, '0);
    send_op(FUNC_PUSH, 2'd0, 64'h5a, '0);
    send_op(FUNC_PUSH, 2'd0, '1, '0);
    // limit dropped under the pointer: pops still work, growth overflows
    set_stack_limit(13'd0);
    send_op(FUNC_POP, 2'd3, '0, '0);
    send_op(FUNC_PUSH, 2'd0, '1, '0);
    send_op(FUNC_DUP, 2'd0, '0, 13'd0);
    send_op(FUNC_DUP, 2'd0, '0, 13'd1);
    // limit above the store size is clamped
    set_stack_limit(13'd8191);
    send_op(FUNC_DUP, 2'd0, '0, 13'd24);
    send_op(FUNC_PUSH, 2'd3, {$urandom, $urandom}, '0);

    set_stack_limit(LIMIT_RESET);
    run_mix(150, 45, 35, 15, 1'b0);
    set_stack_limit(13'd0);
    run_mix(60, 30, 50, 15, 1'b0);
    set_stack_limit(13'd8191);
    run_mix(150, 45, 35, 15, 1'($urandom_range(0, 1)));

    // double the stack with duplicates until the store is full
    set_stack_limit(LIMIT_RESET);
    settle_idle();
    if (last_depth == 0) begin
      send_op(FUNC_PUSH, 2'd3, {$urandom, $urandom}, '0);
      settle_idle();
    end
    for (k = 0; k < 16 && last_depth < int'(STACK_BYTES_DEF); k++) begin
      fill = (last_depth < int'(STACK_BYTES_DEF) - last_depth) ?
             last_depth : STACK_BYTES_DEF - last_depth;
      send_op(FUNC_DUP, 2'd0, '0, PTR_W'(fill));
      settle_idle();
    end
    send_op(FUNC_PUSH, 2'd0, '1, '0);
    send_op(FUNC_DUP, 2'd0, '0, 13'd1);

    // hold the result side off while transactions keep coming
    set_stack_limit(13'd64);
    hold_off_reqs++;
    run_mix(40, 10, 60, 15, 1'b1);
    run_mix(150, 20, 60, 15, 1'b0);

    set_stack_limit(PTR_W'($urandom_range(1, 300)));
    rx_quiet = 1'b1;
    run_mix(150, 45, 35, 15, 1'b1);
    rx_quiet = 1'b0;

    settle_idle();
    repeat (40) @(negedge clk);
    $display("covered %0d operations, %0d results compared, %0d overflows, %0d underflows",
             ops_issued, results_seen, overflow_hits, underflow_hits);
    $display("peak depth %0d of %0d bytes; limits 4096, 32, 0, 8191, 64, random; %0d-cycle hold",
             peak_depth, STACK_BYTES_DEF, HOLD_OFF);
    if (mismatches == 0 && results_outstanding == 0) begin
      $display("byte_stack_push_pop_dup_test: done, clean");
    end else begin
      $display("byte_stack_push_pop_dup_test: done, errors");
    end
    $finish;
  end

endmodule
